>>> sv/grid_bilinear_interpolator_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the grid interpolator
// Concurrent checks, clocked on clock and disabled during reset; define
// ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef GRID_BILINEAR_INTERPOLATOR_CORE_MACROS_SVH
`define GRID_BILINEAR_INTERPOLATOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define GBI_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gbi: implication check failed");
// next-cycle implication
`define GBI_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gbi: next-cycle check failed");
`else
`define GBI_ASSERT_IMP(label, ante, cons)
`define GBI_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> sv/gbi_pkg.sv
// ----------------------------------------------------------------------------
// gbi_pkg
// Shared widths, codes and types of the grid bilinear interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gbi_pkg;

   localparam int DEF_MAX_ROWS = 32;
   localparam int DEF_MAX_COLS = 64;

   localparam int COORD_W     = 32;
   localparam int VALUE_W     = 16;
   localparam int OP_W        = 2;
   localparam int ROW_IDX_W   = 5;
   localparam int COL_IDX_W   = 6;
   localparam int ROW_CNT_W   = 6;
   localparam int COL_CNT_W   = 7;
   localparam int STATUS_W    = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 7;

   // Q0.16 weight with one extra bit so 1.0 is representable
   localparam int FRAC_W      = 16;
   localparam int WEIGHT_W    = FRAC_W + 1;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_W;

   // blend accumulator: four corners of 2^32 * 65535 at most
   localparam int WPROD_W     = 2 * WEIGHT_W;
   localparam int ACC_W       = 49;

   localparam logic [OP_W-1:0] OP_WR_ROW   = 2'd0;
   localparam logic [OP_W-1:0] OP_WR_COL   = 2'd1;
   localparam logic [OP_W-1:0] OP_WR_VALUE = 2'd2;
   localparam logic [OP_W-1:0] OP_QUERY    = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DEGEN   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 1'b1;

   // outcome of one axis search
   typedef struct packed {
      logic               done;
      logic               outside;
      logic [COORD_W-1:0] lo;
      logic [COORD_W-1:0] hi;
   } axis_result_type;

endpackage

`default_nettype wire

>>> sv/gbi_knot_axis.sv
// ----------------------------------------------------------------------------
// gbi_knot_axis
// Knot memory of one axis with span check, upper-bound scan and cell fetch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbi_knot_axis
   import gbi_pkg::*;
#(
   parameter int DEPTH = 32,
   parameter int IW    = 5,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire logic [IW-1:0]      wr_idx,
   input  wire logic [COORD_W-1:0] wr_data,
   input  wire logic               start,
   input  wire logic [CW-1:0]      count,
   input  wire logic [COORD_W-1:0] point,
   output axis_result_type         result,
   output logic [AW-1:0]           cell_idx
);

   localparam logic [2:0] A_IDLE  = 3'd0;
   localparam logic [2:0] A_FIRST = 3'd1;
   localparam logic [2:0] A_LAST  = 3'd2;
   localparam logic [2:0] A_SCAN  = 3'd3;
   localparam logic [2:0] A_LO    = 3'd4;
   localparam logic [2:0] A_HI    = 3'd5;
   localparam logic [2:0] A_DONE  = 3'd6;

   logic [COORD_W-1:0] mem [DEPTH];
   logic [COORD_W-1:0] rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               wr_ok;

   logic [2:0]         state_ff, state_in;
   logic [COORD_W-1:0] point_ff, first_ff, lo_ff, hi_ff;
   logic [CW-1:0]      count_ff;
   logic [AW-1:0]      cmp_ff, cmp_in, cell_ff, cell_in;
   logic               outside_ff, outside_in;

   logic [AW-1:0]      last_idx;
   logic               hit, scan_end, span_out;
   logic [CW-1:0]      kraw, kclamp;

   assign wr_ok    = 32'(wr_idx) < DEPTH;
   assign last_idx = AW'(count_ff - CW'(1));
   assign hit      = rd_data_ff > point_ff;
   assign scan_end = cmp_ff == last_idx;
   assign span_out = (point_ff < first_ff) || (point_ff > rd_data_ff);

   // first knot above the point (count if none), clamped to 1 .. count-1
   always_comb begin
      kraw = hit ? CW'(cmp_ff) : count_ff;
      if (kraw == '0) begin
         kclamp = CW'(1);
      end else if (kraw > count_ff - CW'(1)) begin
         kclamp = count_ff - CW'(1);
      end else begin
         kclamp = kraw;
      end
   end

   // sequence the probes
   always_comb begin
      state_in   = state_ff;
      cmp_in     = cmp_ff;
      cell_in    = cell_ff;
      outside_in = outside_ff;
      rd_addr    = '0;
      unique case (state_ff)
         A_IDLE: begin
            if (start) begin
               state_in   = A_FIRST;
               outside_in = 1'b0;
            end
         end
         A_FIRST: begin
            rd_addr  = last_idx;
            state_in = A_LAST;
         end
         A_LAST: begin
            cmp_in = '0;
            if (span_out) begin
               outside_in = 1'b1;
               state_in   = A_DONE;
            end else begin
               state_in = A_SCAN;
            end
         end
         A_SCAN: begin
            if (hit || scan_end) begin
               cell_in  = AW'(kclamp);
               rd_addr  = AW'(kclamp - CW'(1));
               state_in = A_LO;
            end else begin
               cmp_in  = cmp_ff + AW'(1);
               rd_addr = cmp_ff + AW'(1);
            end
         end
         A_LO: begin
            rd_addr  = cell_ff;
            state_in = A_HI;
         end
         A_HI: begin
            state_in = A_DONE;
         end
         A_DONE: begin
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= A_IDLE;
         outside_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         outside_ff <= outside_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cmp_ff  <= cmp_in;
      cell_ff <= cell_in;
      if (state_ff == A_IDLE && start) begin
         point_ff <= point;
         count_ff <= count;
      end
      if (state_ff == A_FIRST) begin
         first_ff <= rd_data_ff;
      end
      if (state_ff == A_LO) begin
         lo_ff <= rd_data_ff;
      end
      if (state_ff == A_HI) begin
         hi_ff <= rd_data_ff;
      end
   end

   // knot memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en && wr_ok) begin
         mem[AW'(wr_idx)] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign result.done    = state_ff == A_DONE;
   assign result.outside = outside_ff;
   assign result.lo      = lo_ff;
   assign result.hi      = hi_ff;
   assign cell_idx       = cell_ff;

endmodule

`default_nettype wire

>>> sv/gbi_weight_div.sv
// ----------------------------------------------------------------------------
// gbi_weight_div
// Serial restoring divider for a Q0.16 interpolation weight, one bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbi_weight_div
   import gbi_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [COORD_W-1:0]  point,
   input  wire logic [COORD_W-1:0]  lo,
   input  wire logic [COORD_W-1:0]  hi,
   output logic                     done,
   output logic [WEIGHT_W-1:0]      weight
);

   localparam int STEP_W = $clog2(FRAC_W);

   logic                busy_ff, done_ff;
   logic [COORD_W-1:0]  rem_ff, den_ff;
   logic [FRAC_W-1:0]   quo_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [WEIGHT_W-1:0] weight_ff;

   logic [COORD_W:0]    rem2;
   logic                ge;
   logic [COORD_W-1:0]  rem_next;
   logic [FRAC_W-1:0]   quo_next;

   // one quotient bit per step
   assign rem2     = {rem_ff, 1'b0};
   assign ge       = rem2 >= {1'b0, den_ff};
   assign rem_next = ge ? COORD_W'(rem2 - {1'b0, den_ff}) : rem2[COORD_W-1:0];
   assign quo_next = {quo_ff[FRAC_W-2:0], ge};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= (point > lo) && (point < hi);
            done_ff <= !((point > lo) && (point < hi));
         end else if (busy_ff && step_ff == STEP_W'(FRAC_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // datapath: saturate at the cell edges, else divide
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= point - lo;
         den_ff  <= hi - lo;
         quo_ff  <= '0;
         step_ff <= '0;
         if (point <= lo) begin
            weight_ff <= '0;
         end else if (point >= hi) begin
            weight_ff <= WEIGHT_ONE;
         end
      end else if (busy_ff) begin
         rem_ff  <= rem_next;
         quo_ff  <= quo_next;
         step_ff <= step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(FRAC_W - 1)) begin
            weight_ff <= {1'b0, quo_next};
         end
      end
   end

   assign done   = done_ff;
   assign weight = weight_ff;

endmodule

`default_nettype wire

>>> sv/gbi_value_store.sv
// ----------------------------------------------------------------------------
// gbi_value_store
// Grid value table: one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbi_value_store
   import gbi_pkg::*;
#(
   parameter int DEPTH = 2048,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire logic [VALUE_W-1:0] wr_data,
   input  wire logic [AW-1:0]      rd_addr,
   output logic [VALUE_W-1:0]      rd_data
);

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   // write and read the table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/grid_bilinear_interpolator_core.sv
// ----------------------------------------------------------------------------
// grid_bilinear_interpolator_core
// Rectilinear-grid bilinear interpolator with knot and value memories.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one item per transfer. Opcodes 0..2 write a row
//   knot, a column knot or a grid value; they complete in the transfer cycle
//   and give no response. Opcode 3 queries a point and gives one rsp
//   transfer with the Q2.14 value and a status (ok, outside, degenerate).
//   Each axis scans its knot memory one probe a cycle, up to the knot count
//   in use. A query runs through the span check, the scan, the cell fetch,
//   serial division with its handoff, blending through the single value-table
//   read port and the load of the output register. One item is in work at a
//   time; req_ready drops for the duration of a query.
//   The response sits in an output register: a stalled receiver holds it,
//   and the block keeps accepting writes and starts the next query, which
//   waits at the end until the register frees.
//   The user writes the knot counts through the csr port (index 0 rows,
//   1 columns) only while the block is idle; the block itself does not enforce this.
//   Reset returns both counts to 2 and clears the handshake; memory contents
//   are undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "grid_bilinear_interpolator_core_macros.svh"

module grid_bilinear_interpolator_core
   import gbi_pkg::*;
#(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [OP_W-1:0]       req_opcode,
   input  wire logic [ROW_IDX_W-1:0]  req_row_index,
   input  wire logic [COL_IDX_W-1:0]  req_col_index,
   input  wire logic [COORD_W-1:0]    req_row_coord,
   input  wire logic [COORD_W-1:0]    req_col_coord,
   input  wire logic [VALUE_W-1:0]    req_grid_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [VALUE_W-1:0]         rsp_interp_value,
   output logic [STATUS_W-1:0]        rsp_status,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RCW = $clog2(MAX_ROWS + 1);
   localparam int CCW = $clog2(MAX_COLS + 1);
   localparam int VDEPTH = MAX_ROWS * MAX_COLS;
   localparam int VAW = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SRCH  = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_BLEND = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [ROW_CNT_W-1:0] row_count_ff;
   logic [COL_CNT_W-1:0] col_count_ff;
   logic [RCW-1:0]       row_n;
   logic [CCW-1:0]       col_n;

   logic                 accept, query_start;
   logic                 row_done_ff, col_done_ff, rdiv_done_ff, cdiv_done_ff;
   axis_result_type      row_res, col_res;
   logic [RAW-1:0]       row_cell;
   logic [CAW-1:0]       col_cell;
   logic [COORD_W-1:0]   q_row_ff, q_col_ff;

   logic                 div_start;
   logic                 rdiv_done, cdiv_done;
   logic [WEIGHT_W-1:0]  rdiv_w, cdiv_w, wr_ff, wc_ff;

   logic                 val_wr_en;
   logic [VAW-1:0]       val_wr_addr, val_rd_addr;
   logic [VALUE_W-1:0]   val_rd_data;

   logic [2:0]           blend_cnt_ff;
   logic [1:0]           corner;
   logic                 issue;
   logic                 v1_ff, v2_ff;
   logic [WPROD_W-1:0]   wp_ff;
   logic [ACC_W-1:0]     prod_ff, acc_ff, acc_rnd;
   logic [RAW-1:0]       corner_row;
   logic [CAW-1:0]       corner_col;
   logic [WEIGHT_W-1:0]  wsel_r, wsel_c;
   logic                 blend_end;

   logic [VALUE_W-1:0]   res_value_ff;
   logic [STATUS_W-1:0]  res_status_ff;
   logic                 rsp_valid_ff;
   logic [VALUE_W-1:0]   rsp_value_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;

   assign req_ready   = state_ff == S_IDLE;
   assign accept      = req_valid && req_ready;
   assign query_start = accept && req_opcode == OP_QUERY;

   // clamp the counts in use to 2 .. maximum
   always_comb begin
      if (row_count_ff < ROW_CNT_W'(2)) begin
         row_n = RCW'(2);
      end else if (32'(row_count_ff) > MAX_ROWS) begin
         row_n = RCW'(MAX_ROWS);
      end else begin
         row_n = RCW'(row_count_ff);
      end
      if (col_count_ff < COL_CNT_W'(2)) begin
         col_n = CCW'(2);
      end else if (32'(col_count_ff) > MAX_COLS) begin
         col_n = CCW'(MAX_COLS);
      end else begin
         col_n = CCW'(col_count_ff);
      end
   end

   // count registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= ROW_CNT_W'(2);
         col_count_ff <= COL_CNT_W'(2);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ROW_COUNT: row_count_ff <= csr_write_data[ROW_CNT_W-1:0];
            CSR_COL_COUNT: col_count_ff <= csr_write_data[COL_CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   gbi_knot_axis #(
      .DEPTH (MAX_ROWS),
      .IW    (ROW_IDX_W)
   ) u_row_axis (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept && req_opcode == OP_WR_ROW),
      .wr_idx   (req_row_index),
      .wr_data  (req_row_coord),
      .start    (query_start),
      .count    (row_n),
      .point    (req_row_coord),
      .result   (row_res),
      .cell_idx (row_cell)
   );

   gbi_knot_axis #(
      .DEPTH (MAX_COLS),
      .IW    (COL_IDX_W)
   ) u_col_axis (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept && req_opcode == OP_WR_COL),
      .wr_idx   (req_col_index),
      .wr_data  (req_col_coord),
      .start    (query_start),
      .count    (col_n),
      .point    (req_col_coord),
      .result   (col_res),
      .cell_idx (col_cell)
   );

   gbi_weight_div u_row_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .point  (q_row_ff),
      .lo     (row_res.lo),
      .hi     (row_res.hi),
      .done   (rdiv_done),
      .weight (rdiv_w)
   );

   gbi_weight_div u_col_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .point  (q_col_ff),
      .lo     (col_res.lo),
      .hi     (col_res.hi),
      .done   (cdiv_done),
      .weight (cdiv_w)
   );

   // grid value writes, dropped when an index lies beyond the table
   assign val_wr_en   = accept && req_opcode == OP_WR_VALUE &&
                        32'(req_row_index) < MAX_ROWS && 32'(req_col_index) < MAX_COLS;
   assign val_wr_addr = VAW'(32'(req_row_index) * MAX_COLS + 32'(req_col_index));

   // corner select: high bit picks the upper row, low bit the upper column
   assign corner     = blend_cnt_ff[1:0];
   assign issue      = state_ff == S_BLEND && !blend_cnt_ff[2];
   assign corner_row = corner[1] ? row_cell : row_cell - RAW'(1);
   assign corner_col = corner[0] ? col_cell : col_cell - CAW'(1);
   assign wsel_r     = corner[1] ? wr_ff : WEIGHT_ONE - wr_ff;
   assign wsel_c     = corner[0] ? wc_ff : WEIGHT_ONE - wc_ff;
   assign val_rd_addr = VAW'(32'(corner_row) * MAX_COLS + 32'(corner_col));
   assign blend_end  = blend_cnt_ff[2] && !v1_ff && !v2_ff;
   assign acc_rnd    = acc_ff + ACC_W'(64'h8000_0000);

   gbi_value_store #(
      .DEPTH (VDEPTH)
   ) u_values (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (req_grid_value),
      .rd_addr (val_rd_addr),
      .rd_data (val_rd_data)
   );

   assign div_start = state_ff == S_SRCH && row_done_ff && col_done_ff &&
                      !row_res.outside && !col_res.outside &&
                      row_res.hi > row_res.lo && col_res.hi > col_res.lo;

   // query sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (query_start) begin
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (row_done_ff && col_done_ff) begin
               state_in = div_start ? S_DIV : S_OUT;
            end
         end
         S_DIV: begin
            if (rdiv_done_ff && cdiv_done_ff) begin
               state_in = S_BLEND;
            end
         end
         S_BLEND: begin
            if (blend_end) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_done_ff  <= 1'b0;
         col_done_ff  <= 1'b0;
         rdiv_done_ff <= 1'b0;
         cdiv_done_ff <= 1'b0;
         blend_cnt_ff <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // hold each unit's completion until the sequencer moves on
         if (query_start) begin
            row_done_ff <= 1'b0;
            col_done_ff <= 1'b0;
         end else begin
            row_done_ff <= row_done_ff || row_res.done;
            col_done_ff <= col_done_ff || col_res.done;
         end
         if (div_start) begin
            rdiv_done_ff <= 1'b0;
            cdiv_done_ff <= 1'b0;
            blend_cnt_ff <= '0;
         end else begin
            rdiv_done_ff <= rdiv_done_ff || rdiv_done;
            cdiv_done_ff <= cdiv_done_ff || cdiv_done;
            if (issue) begin
               blend_cnt_ff <= blend_cnt_ff + 3'd1;
            end
         end
         v1_ff <= issue;
         v2_ff <= v1_ff;
         // output register
         if (state_ff == S_OUT && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (query_start) begin
         q_row_ff <= req_row_coord;
         q_col_ff <= req_col_coord;
      end
      if (rdiv_done) begin
         wr_ff <= rdiv_w;
      end
      if (cdiv_done) begin
         wc_ff <= cdiv_w;
      end
      // weight product, then times the corner value, then accumulate
      wp_ff   <= wsel_r * wsel_c;
      prod_ff <= ACC_W'(wp_ff * val_rd_data);
      if (div_start) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + prod_ff;
      end
      // result of the query
      if (state_ff == S_SRCH && row_done_ff && col_done_ff) begin
         res_value_ff <= '0;
         if (row_res.outside || col_res.outside) begin
            res_status_ff <= ST_OUTSIDE;
         end else if (!div_start) begin
            res_status_ff <= ST_DEGEN;
         end else begin
            res_status_ff <= ST_OK;
         end
      end else if (state_ff == S_BLEND && blend_end) begin
         res_value_ff <= acc_rnd[2*FRAC_W +: VALUE_W];
      end
      if (state_ff == S_OUT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_value_ff  <= res_value_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interp_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

   `GBI_ASSERT_IMP(a_err_zero, rsp_valid_ff && rsp_status_ff != ST_OK, rsp_value_ff == '0)
   `GBI_ASSERT_NEXT(a_query_starts, query_start, state_ff == S_SRCH)
   `GBI_ASSERT_IMP(a_cell_in_range, state_ff == S_BLEND, row_cell != '0 && col_cell != '0)
   `GBI_ASSERT_IMP(a_rsp_from_out, $rose(rsp_valid_ff), $past(state_ff) == S_OUT)

endmodule

`default_nettype wire

>>> test/tb_grid_bilinear_interpolator_core.sv
// ----------------------------------------------------------------------------
// tb_grid_bilinear_interpolator_core
// Self-checking bench for the grid interpolator: loads knots and grid values,
// queries points through the req/rsp handshakes and checks every response
// with set values or an in-bench bilinear predictor, over several knot counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_grid_bilinear_interpolator_core;
   import gbi_pkg::*;

   localparam int N_ROWS     = DEF_MAX_ROWS;
   localparam int N_COLS     = DEF_MAX_COLS;
   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE     = 150;
   localparam int RAND_ITEMS = 10;

   typedef struct {
      logic [OP_W-1:0]      op;
      logic [ROW_IDX_W-1:0] ri;
      logic [COL_IDX_W-1:0] ci;
      logic [COORD_W-1:0]   rc;
      logic [COORD_W-1:0]   cc;
      logic [VALUE_W-1:0]   gv;
      bit                   typed;
      logic [VALUE_W-1:0]   ev;
      logic [STATUS_W-1:0]  es;
   } grid_op_type;

   typedef struct {
      logic [VALUE_W-1:0]  value;
      logic [STATUS_W-1:0] status;
   } interp_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [OP_W-1:0]       req_opcode;
   logic [ROW_IDX_W-1:0]  req_row_index;
   logic [COL_IDX_W-1:0]  req_col_index;
   logic [COORD_W-1:0]    req_row_coord;
   logic [COORD_W-1:0]    req_col_coord;
   logic [VALUE_W-1:0]    req_grid_value;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [VALUE_W-1:0]    rsp_interp_value;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   // shadow state of the block
   logic [COORD_W-1:0]   row_knot_mem [N_ROWS];
   logic [COORD_W-1:0]   col_knot_mem [N_COLS];
   logic [VALUE_W-1:0]   value_mem [N_ROWS*N_COLS];
   bit                   value_seen [N_ROWS*N_COLS];
   logic [ROW_CNT_W-1:0] row_count_reg;
   logic [COL_CNT_W-1:0] col_count_reg;

   interp_result_type pending_results[$];
   grid_op_type       directed_ops[$];
   bit             no_idle;
   int             error_count;
   int             mismatch_count;
   int             idle_cycles;
   int             n_writes, n_ok, n_outside, n_degen;

   grid_bilinear_interpolator_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_row_index    (req_row_index),
      .req_col_index    (req_col_index),
      .req_row_coord    (req_row_coord),
      .req_col_coord    (req_col_coord),
      .req_grid_value   (req_grid_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_interp_value (rsp_interp_value),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int rows_in_use();
      if (row_count_reg < 2) return 2;
      if (row_count_reg > N_ROWS) return N_ROWS;
      return row_count_reg;
   endfunction

   function automatic int cols_in_use();
      if (col_count_reg < 2) return 2;
      if (col_count_reg > N_COLS) return N_COLS;
      return col_count_reg;
   endfunction

   function automatic logic [COORD_W-1:0] knot_at(bit col_axis, int k);
      return col_axis ? col_knot_mem[k] : row_knot_mem[k];
   endfunction

   // upper-bound search, cell clamped to 1 .. n-1
   function automatic int upper_cell(bit col_axis, int n, logic [COORD_W-1:0] p);
      int k;
      k = n;
      for (int t = n - 1; t >= 0; t--) begin
         if (knot_at(col_axis, t) > p) k = t;
      end
      if (k < 1) k = 1;
      if (k > n - 1) k = n - 1;
      return k;
   endfunction

   function automatic logic [63:0] blend_weight(logic [31:0] p, logic [31:0] lo,
                                                logic [31:0] hi);
      logic [63:0] w;
      if (p <= lo) return 64'd0;
      if (p >= hi) return 64'd65536;
      w = {16'd0, p - lo, 16'd0} / {32'd0, hi - lo};
      if (w > 64'd65536) w = 64'd65536;
      return w;
   endfunction

   // predicted response of one query, plus the cell it lands in
   function automatic void predict_query(input logic [COORD_W-1:0] rc,
                                         input logic [COORD_W-1:0] cc,
                                         output interp_result_type res,
                                         output int cell_r, output int cell_c);
      int nr, nc;
      logic [31:0] r1, r2, c1, c2;
      logic [63:0] wr, wc, ir, ic, sum;
      nr = rows_in_use();
      nc = cols_in_use();
      cell_r = upper_cell(1'b0, nr, rc);
      cell_c = upper_cell(1'b1, nc, cc);
      r1 = row_knot_mem[cell_r-1];
      r2 = row_knot_mem[cell_r];
      c1 = col_knot_mem[cell_c-1];
      c2 = col_knot_mem[cell_c];
      res.value = '0;
      if (rc < row_knot_mem[0] || rc > row_knot_mem[nr-1] ||
          cc < col_knot_mem[0] || cc > col_knot_mem[nc-1]) begin
         res.status = ST_OUTSIDE;
      end else if (r2 <= r1 || c2 <= c1) begin
         res.status = ST_DEGEN;
      end else begin
         wr = blend_weight(rc, r1, r2);
         wc = blend_weight(cc, c1, c2);
         ir = 64'd65536 - wr;
         ic = 64'd65536 - wc;
         sum = ir * ic * value_mem[(cell_r-1)*N_COLS + cell_c-1]
             + ir * wc * value_mem[(cell_r-1)*N_COLS + cell_c]
             + wr * ic * value_mem[cell_r*N_COLS + cell_c-1]
             + wr * wc * value_mem[cell_r*N_COLS + cell_c];
         sum = (sum + 64'h8000_0000) >> 32;
         res.value  = sum[VALUE_W-1:0];
         res.status = ST_OK;
      end
   endfunction

   function automatic grid_op_type make_op(logic [OP_W-1:0] op, int ri, int ci,
                                        logic [31:0] rc, logic [31:0] cc,
                                        logic [15:0] gv, bit typed = 0,
                                        logic [15:0] ev = 0,
                                        logic [STATUS_W-1:0] es = ST_OK);
      grid_op_type g;
      g.op = op; g.ri = ri; g.ci = ci; g.rc = rc; g.cc = cc; g.gv = gv;
      g.typed = typed; g.ev = ev; g.es = es;
      return g;
   endfunction

   function automatic grid_op_type noisy_write(logic [OP_W-1:0] op, int ri, int ci,
                                            logic [31:0] rc, logic [31:0] cc,
                                            logic [15:0] gv);
      return make_op(op, ri, ci, rc, cc, gv);
   endfunction

   // drive one item, wait for the transfer and update the shadow state
   task automatic send_op(input grid_op_type item);
      int gap;
      interp_result_type res;
      int cr, cc;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_opcode     = item.op;
      req_row_index  = item.ri;
      req_col_index  = item.ci;
      req_row_coord  = item.rc;
      req_col_coord  = item.cc;
      req_grid_value = item.gv;
      do @(posedge clock); while (!req_ready);
      case (item.op)
         OP_WR_ROW: begin
            row_knot_mem[item.ri] = item.rc;
            n_writes++;
         end
         OP_WR_COL: begin
            col_knot_mem[item.ci] = item.cc;
            n_writes++;
         end
         OP_WR_VALUE: begin
            value_mem[item.ri*N_COLS + item.ci]  = item.gv;
            value_seen[item.ri*N_COLS + item.ci] = 1'b1;
            n_writes++;
         end
         default: begin
            predict_query(item.rc, item.cc, res, cr, cc);
            if (item.typed) begin
               res.value  = item.ev;
               res.status = item.es;
            end
            case (res.status)
               ST_OK:      n_ok++;
               ST_OUTSIDE: n_outside++;
               default:    n_degen++;
            endcase
            pending_results.push_back(res);
         end
      endcase
      @(negedge clock);
      // drop valid until the next item is offered
      req_valid = 1'b0;
   endtask

   // write any corner of the target cell not yet written, then query
   task automatic query_point(input logic [31:0] rc, input logic [31:0] cc);
      interp_result_type res;
      int cr, ccl, idx;
      predict_query(rc, cc, res, cr, ccl);
      for (int dr = -1; dr <= 0; dr++) begin
         for (int dc = -1; dc <= 0; dc++) begin
            idx = (cr + dr) * N_COLS + ccl + dc;
            if (!value_seen[idx])
               send_op(noisy_write(OP_WR_VALUE, cr + dr, ccl + dc, $urandom,
                                   $urandom, $urandom));
         end
      end
      send_op(make_op(OP_QUERY, $urandom, $urandom, rc, cc, $urandom));
   endtask

   // wait for the block to drain, then write one count register
   task automatic write_count(input logic [CSR_IDX_W-1:0] idx, input int data);
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (idx == CSR_ROW_COUNT) row_count_reg = data;
      else col_count_reg = data;
   endtask

   // load knots 0 .. n-1: mostly increasing, sometimes repeated or shuffled
   task automatic load_knots(input bit col_axis, input int n);
      logic [31:0] q[$];
      int mode, k;
      bit wide;
      mode = $urandom_range(0, 9);
      wide = $urandom_range(0, 1);
      for (int t = 0; t < n; t++)
         q.push_back(wide ? $urandom : ($urandom_range(0, 60) << 14) + $urandom_range(0, 3));
      if (mode != 0) q.sort();
      if (mode == 1) begin
         k = $urandom_range(1, n - 1);
         q[k] = q[k-1];
      end
      for (int t = 0; t < n; t++) begin
         if (col_axis) send_op(noisy_write(OP_WR_COL, $urandom, t, $urandom, q[t], $urandom));
         else send_op(noisy_write(OP_WR_ROW, t, $urandom, q[t], $urandom, $urandom));
      end
   endtask

   function automatic logic [31:0] pick_coord(bit col_axis, int n);
      logic [31:0] lo, hi;
      logic [63:0] span;
      lo = knot_at(col_axis, 0);
      hi = knot_at(col_axis, n - 1);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return knot_at(col_axis, $urandom_range(0, n - 1));
         default: begin
            if (hi < lo) return $urandom;
            span = {32'd0, hi - lo} + 64'd1;
            return lo + 32'({$urandom, $urandom} % span);
         end
      endcase
   endfunction

   // stall responses at random through rsp_ready
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 11);
         rsp_ready = 1'b0;
         repeat (stall) @(negedge clock);
         rsp_ready = 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // check each response against the oldest prediction
   always @(posedge clock) begin
      interp_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            $display("unexpected response value=%h status=%0d",
                     rsp_interp_value, rsp_status);
         end else begin
            want = pending_results.pop_front();
            if (rsp_interp_value !== want.value || rsp_status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                           want.value, want.status, rsp_interp_value, rsp_status);
            end
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      int row_set[8];
      int col_set[8];
      int nr, nc;
      int prev_nr, prev_nc;
      row_set = '{0, 1, 32, 63, 33, 3, 0, 0};
      col_set = '{1, 0, 64, 127, 65, 5, 0, 0};
      prev_nr = 0;
      prev_nc = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_WR_ROW;
      req_row_index = '0;
      req_col_index = '0;
      req_row_coord = '0;
      req_col_coord = '0;
      req_grid_value = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_ROW_COUNT;
      csr_write_data = '0;
      row_count_reg = 2;
      col_count_reg = 2;
      no_idle = 1'b0;
      error_count = 0;
      mismatch_count = 0;
      idle_cycles = 0;
      n_writes = 0; n_ok = 0; n_outside = 0; n_degen = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part on the reset counts of two knots per axis
      directed_ops.push_back(make_op(OP_WR_ROW, 0, 0, 32'h0, 32'h0, 16'h0));
      directed_ops.push_back(make_op(OP_WR_ROW, 1, 0, 32'hFFFF_FFFF, 32'h0, 16'h0));
      directed_ops.push_back(make_op(OP_WR_COL, 0, 0, 32'h0, 32'h0, 16'h0));
      directed_ops.push_back(make_op(OP_WR_COL, 0, 1, 32'h0, 32'hFFFF_FFFF, 16'h0));
      directed_ops.push_back(make_op(OP_WR_VALUE, 0, 0, 0, 0, 16'hFFFF));
      directed_ops.push_back(make_op(OP_WR_VALUE, 0, 1, 0, 0, 16'hFFFF));
      directed_ops.push_back(make_op(OP_WR_VALUE, 1, 0, 0, 0, 16'hFFFF));
      directed_ops.push_back(make_op(OP_WR_VALUE, 1, 1, 0, 0, 16'hFFFF));
      directed_ops.push_back(make_op(OP_QUERY, 0, 0, 32'h0, 32'h0, 0, 1, 16'hFFFF, ST_OK));
      directed_ops.push_back(make_op(OP_QUERY, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0,
                                     1, 16'hFFFF, ST_OK));
      directed_ops.push_back(make_op(OP_QUERY, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                                     1, 16'hFFFF, ST_OK));
      directed_ops.push_back(make_op(OP_WR_VALUE, 0, 0, 0, 0, 16'h0000));
      directed_ops.push_back(make_op(OP_QUERY, 0, 0, 32'h0, 32'h0, 0, 1, 16'h0, ST_OK));
      directed_ops.push_back(make_op(OP_QUERY, 0, 0, 32'h4000_0000, 32'hC000_0000, 0));
      directed_ops.push_back(make_op(OP_WR_VALUE, 1, 0, 0, 0, 16'h1234));
      directed_ops.push_back(make_op(OP_QUERY, 0, 0, 32'h1234_5678, 32'h0000_0100, 0));
      directed_ops.push_back(make_op(OP_WR_ROW, 1, 0, 32'h0001_0000, 32'h0, 16'h0));
      directed_ops.push_back(make_op(OP_QUERY, 0, 0, 32'h0002_0000, 32'h0, 0,
                                     1, 16'h0, ST_OUTSIDE));
      directed_ops.push_back(make_op(OP_QUERY, 0, 0, 32'h0000_8000, 32'h0, 0));
      directed_ops.push_back(make_op(OP_WR_ROW, 1, 0, 32'h0, 32'h0, 16'h0));
      directed_ops.push_back(make_op(OP_QUERY, 0, 0, 32'h0, 32'h0, 0, 1, 16'h0, ST_DEGEN));
      directed_ops.push_back(make_op(OP_WR_ROW, 31, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
      directed_ops.push_back(make_op(OP_WR_COL, 31, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
      directed_ops.push_back(make_op(OP_WR_VALUE, 31, 63, 0, 0, 16'hFFFF));
      directed_ops.push_back(make_op(OP_WR_ROW, 1, 0, 32'h0003_0000, 32'h0, 16'h0));
      foreach (directed_ops[k]) send_op(directed_ops[k]);

      // random phases over several knot-count settings
      row_set[6] = $urandom_range(0, 63);
      col_set[6] = $urandom_range(0, 127);
      row_set[7] = $urandom_range(2, 8);
      col_set[7] = $urandom_range(2, 8);
      for (int ph = 0; ph < 8; ph++) begin
         write_count(CSR_ROW_COUNT, row_set[ph]);
         write_count(CSR_COL_COUNT, col_set[ph]);
         no_idle = (ph % 3 == 2);
         nr = rows_in_use();
         nc = cols_in_use();
         // reload an axis only when its knot count in use changes
         if (nr != prev_nr) load_knots(1'b0, nr);
         if (nc != prev_nc) load_knots(1'b1, nc);
         prev_nr = nr;
         prev_nc = nc;
         for (int n = 0; n < RAND_ITEMS; n++) begin
            case ($urandom_range(0, 9))
               0: send_op(noisy_write(OP_WR_ROW, $urandom, $urandom, $urandom,
                                      $urandom, $urandom));
               1: send_op(noisy_write(OP_WR_COL, $urandom, $urandom, $urandom,
                                      $urandom, $urandom));
               2: send_op(noisy_write(OP_WR_VALUE, $urandom, $urandom, $urandom,
                                      $urandom, $urandom));
               default: query_point(pick_coord(1'b0, nr), pick_coord(1'b1, nc));
            endcase
         end
      end

      // drain and settle
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);

      $display("run covered %0d writes and %0d queries over 9 count settings",
               n_writes, n_ok + n_outside + n_degen);
      $display("query outcomes: %0d in grid, %0d outside, %0d degenerate; %0d mismatches",
               n_ok, n_outside, n_degen, mismatch_count);
      if (error_count == 0 && mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+sv
sv/gbi_pkg.sv
sv/gbi_knot_axis.sv
sv/gbi_weight_div.sv
sv/gbi_value_store.sv
sv/grid_bilinear_interpolator_core.sv
test/tb_grid_bilinear_interpolator_core.sv
